[design/two_way_lru_cache_tag_lookup_macros.svh]
// Assertion macros for the two-way LRU cache tag lookup.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef TWO_WAY_LRU_CACHE_TAG_LOOKUP_MACROS_SVH
`define TWO_WAY_LRU_CACHE_TAG_LOOKUP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tlk_pkg.sv]
// Shared types and constants for the two-way LRU cache tag lookup.
// No dependencies; used by tlk_front, tlk_back and the top level.
package tlk_pkg;

  localparam int ADDR_W    = 32;
  localparam int OFFSET_W  = 5;
  localparam int BLOCK_W   = 27;
  localparam int SET_OUT_W = 6;
  localparam int TAG_W     = 21;
  localparam int COUNT_W   = 32;

  localparam logic WAY0 = 1'b0;
  localparam logic WAY1 = 1'b1;

  typedef struct packed {
    logic [OFFSET_W-1:0]  byte_offset;
    logic [BLOCK_W-1:0]   block_number;
    logic [SET_OUT_W-1:0] set_index;
    logic [TAG_W-1:0]     tag;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag0;
    logic [TAG_W-1:0] tag1;
    logic             valid0;
    logic             valid1;
    logic             recent;
  } entry_t;

  typedef struct packed {
    req_t               req;
    logic               way;
    logic               miss;
    logic               replacement;
    logic [TAG_W-1:0]   evicted_tag;
    logic [COUNT_W-1:0] miss_count;
    logic [COUNT_W-1:0] access_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

[design/tlk_front.sv]
// Front end of the tag lookup: splits each address into its fields and holds
// them in a two-entry queue for the back end. Depends on tlk_pkg.
module tlk_front #(
  parameter int SETS       = 64,
  parameter int LINE_BYTES = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr,
  input  logic [tlk_pkg::ADDR_W-1:0] address,
  output logic                       fq_full,
  output logic                       fq_valid,
  input  logic                       fq_pop,
  output tlk_pkg::req_t              fq_req,
  output logic [$clog2(SETS)-1:0]    fq_idx
);
  import tlk_pkg::*;

  localparam int OFF_W = $clog2(LINE_BYTES);
  localparam int SET_W = $clog2(SETS);

  logic [ADDR_W-1:0] blk_full;
  logic [ADDR_W-1:0] tag_full;
  req_t              dec_req;
  logic [SET_W-1:0]  dec_idx;

  req_t             q_req [2];
  logic [SET_W-1:0] q_idx [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  always_comb begin
    blk_full             = address >> OFF_W;
    tag_full             = blk_full >> SET_W;
    dec_req.byte_offset  = OFFSET_W'(address & ADDR_W'(LINE_BYTES - 1));
    dec_req.block_number = blk_full[BLOCK_W-1:0];
    dec_req.set_index    = SET_OUT_W'(blk_full & ADDR_W'(SETS - 1));
    dec_req.tag          = tag_full[TAG_W-1:0];
    dec_idx              = blk_full[SET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (fq_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, fq_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_req[wr_ptr] <= dec_req;
      q_idx[wr_ptr] <= dec_idx;
    end
  end

  assign fq_full  = (count == 2'd2);
  assign fq_valid = (count != 2'd0);
  assign fq_req   = q_req[rd_ptr];
  assign fq_idx   = q_idx[rd_ptr];

endmodule

[design/tlk_back.sv]
// Back end of the tag lookup: set memory, LRU update, counters and result queue.
// Depends on tlk_pkg; fed by tlk_front.
module tlk_back #(
  parameter int SETS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fq_valid,
  input  tlk_pkg::req_t           fq_req,
  input  logic [$clog2(SETS)-1:0] fq_idx,
  output logic                    fq_pop,
  output logic                    clearing,
  input  logic                    pop,
  output logic                    empty,
  output tlk_pkg::result_t        res
);
  import tlk_pkg::*;

  localparam int SET_W = $clog2(SETS);

  state_t           state;
  state_t           state_next;
  logic [SET_W-1:0] clr_idx;
  logic [SET_W-1:0] clr_idx_next;

  entry_t           mem [SETS];
  entry_t           rd_data;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  req_t             cur_req;
  logic [SET_W-1:0] cur_idx;
  logic             fwd;
  entry_t           fwd_entry;

  entry_t           ent;
  entry_t           new_entry;
  logic             hit0;
  logic             hit1;
  logic             miss;
  logic             fill_way;
  logic             way;
  logic             repl;
  logic [TAG_W-1:0] evicted;

  logic [COUNT_W-1:0] miss_cnt;
  logic [COUNT_W-1:0] acc_cnt;
  logic [COUNT_W-1:0] miss_cnt_next;
  logic [COUNT_W-1:0] acc_cnt_next;

  result_t    ob_data [2];
  result_t    res_new;
  logic       ob_wp;
  logic       ob_rp;
  logic [1:0] ob_cnt;
  logic       ob_push;
  logic       ob_pop;

  // A lookup of the set written in the previous cycle takes the forwarded entry.
  always_comb begin
    ent      = fwd ? fwd_entry : rd_data;
    hit0     = ent.valid0 && (ent.tag0 == cur_req.tag);
    hit1     = ent.valid1 && (ent.tag1 == cur_req.tag);
    miss     = !hit0 && !hit1;
    fill_way = ent.recent ? WAY0 : WAY1;
    priority if (hit0) begin
      way = WAY0;
    end else if (hit1) begin
      way = WAY1;
    end else begin
      way = fill_way;
    end
    repl    = miss && ((fill_way == WAY1) ? ent.valid1 : ent.valid0);
    evicted = '0;
    if (repl) begin
      evicted = (fill_way == WAY1) ? ent.tag1 : ent.tag0;
    end
    new_entry        = ent;
    new_entry.recent = way;
    if (miss) begin
      if (fill_way == WAY1) begin
        new_entry.tag1   = cur_req.tag;
        new_entry.valid1 = 1'b1;
      end else begin
        new_entry.tag0   = cur_req.tag;
        new_entry.valid0 = 1'b1;
      end
    end
    acc_cnt_next  = acc_cnt + COUNT_W'(1);
    miss_cnt_next = miss_cnt + COUNT_W'(miss);

    res_new.req          = cur_req;
    res_new.way          = way;
    res_new.miss         = miss;
    res_new.replacement  = repl;
    res_new.evicted_tag  = evicted;
    res_new.miss_count   = miss_cnt_next;
    res_new.access_count = acc_cnt_next;
  end

  assign ob_pop = pop && (ob_cnt != 2'd0);

  always_comb begin
    state_next   = state;
    clr_idx_next = clr_idx;
    fq_pop       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cur_idx;
    mem_wdata    = new_entry;
    ob_push      = 1'b0;
    clearing     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        clearing         = 1'b1;
        mem_we           = 1'b1;
        mem_waddr        = clr_idx;
        mem_wdata.tag0   = '0;
        mem_wdata.tag1   = '0;
        mem_wdata.valid0 = 1'b0;
        mem_wdata.valid1 = 1'b0;
        mem_wdata.recent = WAY1;
        if (clr_idx == SET_W'(SETS - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_idx_next = clr_idx + SET_W'(1);
        end
      end
      ST_IDLE: begin
        if (fq_valid && (ob_cnt != 2'd2)) begin
          fq_pop     = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        mem_we  = 1'b1;
        ob_push = 1'b1;
        if (fq_valid && ((ob_cnt == 2'd0) || ((ob_cnt == 2'd1) && ob_pop))) begin
          fq_pop = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      fwd      <= 1'b0;
      miss_cnt <= '0;
      acc_cnt  <= '0;
      ob_wp    <= 1'b0;
      ob_rp    <= 1'b0;
      ob_cnt   <= 2'd0;
    end else begin
      state   <= state_next;
      clr_idx <= clr_idx_next;
      if (fq_pop) begin
        fwd <= (state == ST_LOOKUP) && (fq_idx == cur_idx);
      end
      if (ob_push) begin
        miss_cnt <= miss_cnt_next;
        acc_cnt  <= acc_cnt_next;
        ob_wp    <= ~ob_wp;
      end
      if (ob_pop) begin
        ob_rp <= ~ob_rp;
      end
      ob_cnt <= ob_cnt + {1'b0, ob_push} - {1'b0, ob_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (fq_pop) begin
      rd_data   <= mem[fq_idx];
      cur_req   <= fq_req;
      cur_idx   <= fq_idx;
      fwd_entry <= new_entry;
    end
    if (ob_push) begin
      ob_data[ob_wp] <= res_new;
    end
  end

  assign empty = (ob_cnt == 2'd0);
  assign res   = ob_data[ob_rp];

endmodule

[design/two_way_lru_cache_tag_lookup.sv]
// Two-way set-associative tag lookup with LRU replacement; top level.
// A result passes the front queue, the lookup registers and the result queue before it is on the output.
// Throughput: one beat per cycle sustained while the result queue is drained, also for back-to-back
// beats to one set, set by the single read and write port of the set memory in tlk_back.
// Reset: full stays high for SETS cycles while the set memory is cleared one set a cycle.
// Depends on tlk_pkg, tlk_front, tlk_back and two_way_lru_cache_tag_lookup_macros.svh.
`include "two_way_lru_cache_tag_lookup_macros.svh"
module two_way_lru_cache_tag_lookup #(
  parameter int SETS       = 64,
  parameter int LINE_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [tlk_pkg::ADDR_W-1:0]    address,
  output logic                          empty,
  input  logic                          pop,
  output logic [tlk_pkg::OFFSET_W-1:0]  byte_offset,
  output logic [tlk_pkg::BLOCK_W-1:0]   block_number,
  output logic [tlk_pkg::SET_OUT_W-1:0] set_index,
  output logic                          way,
  output logic [tlk_pkg::TAG_W-1:0]     tag,
  output logic                          miss,
  output logic                          replacement,
  output logic [tlk_pkg::TAG_W-1:0]     evicted_tag,
  output logic [tlk_pkg::COUNT_W-1:0]   miss_count,
  output logic [tlk_pkg::COUNT_W-1:0]   access_count
);
  import tlk_pkg::*;

  localparam int SET_W = $clog2(SETS);

  logic             wr;
  logic             fq_full;
  logic             fq_valid;
  logic             fq_pop;
  req_t             fq_req;
  logic [SET_W-1:0] fq_idx;
  logic             clearing;
  result_t          res;

  assign full = fq_full || clearing;
  assign wr   = push && !full;

  tlk_front #(
    .SETS       (SETS),
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .address  (address),
    .fq_full  (fq_full),
    .fq_valid (fq_valid),
    .fq_pop   (fq_pop),
    .fq_req   (fq_req),
    .fq_idx   (fq_idx)
  );

  tlk_back #(
    .SETS (SETS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .fq_valid (fq_valid),
    .fq_req   (fq_req),
    .fq_idx   (fq_idx),
    .fq_pop   (fq_pop),
    .clearing (clearing),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign byte_offset  = res.req.byte_offset;
  assign block_number = res.req.block_number;
  assign set_index    = res.req.set_index;
  assign tag          = res.req.tag;
  assign way          = res.way;
  assign miss         = res.miss;
  assign replacement  = res.replacement;
  assign evicted_tag  = res.evicted_tag;
  assign miss_count   = res.miss_count;
  assign access_count = res.access_count;

  `TLK_ASSERT_SAME(a_hit_no_evict, !empty && !miss, !replacement && (evicted_tag == '0), "hit reports an eviction")
  `TLK_ASSERT_NEXT(a_count_advances, pop && !empty, empty || (access_count != $past(access_count)), "next result repeats the access count")
  `TLK_ASSERT_SAME(a_clear_blocks, $past(rst), full, "input open before the set memory is cleared")

endmodule

[tb/tag_lookup_monitor.sv]
`timescale 1ns / 100ps
// Checker for the two-way LRU cache tag lookup: predicts each lookup result and compares it.
// Depends on tlk_pkg; instantiated by two_way_lru_cache_tag_lookup_test beside the block.
module tag_lookup_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic [tlk_pkg::ADDR_W-1:0]    address,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [tlk_pkg::OFFSET_W-1:0]  byte_offset,
  input  logic [tlk_pkg::BLOCK_W-1:0]   block_number,
  input  logic [tlk_pkg::SET_OUT_W-1:0] set_index,
  input  logic                          way,
  input  logic [tlk_pkg::TAG_W-1:0]     tag,
  input  logic                          miss,
  input  logic                          replacement,
  input  logic [tlk_pkg::TAG_W-1:0]     evicted_tag,
  input  logic [tlk_pkg::COUNT_W-1:0]   miss_count,
  input  logic [tlk_pkg::COUNT_W-1:0]   access_count,
  output int                            failures,
  output int                            pending
);
  import tlk_pkg::*;

  localparam int NUM_SETS = 1 << SET_OUT_W;

  logic [TAG_W-1:0]   tag_way0 [NUM_SETS];
  logic [TAG_W-1:0]   tag_way1 [NUM_SETS];
  logic               valid_way0 [NUM_SETS];
  logic               valid_way1 [NUM_SETS];
  logic               mru_way [NUM_SETS];
  logic [COUNT_W-1:0] misses_total;
  logic [COUNT_W-1:0] accesses_total;
  result_t            expected_lookups [$];
  int                 mismatch_count = 0;
  int                 queued = 0;

  assign failures = mismatch_count;
  assign pending  = queued;

  function automatic result_t predict_lookup(input logic [ADDR_W-1:0] a);
    result_t r;
    logic [SET_OUT_W-1:0] s;
    r = '0;
    r.req.byte_offset  = a[OFFSET_W-1:0];
    r.req.block_number = a[ADDR_W-1:OFFSET_W];
    r.req.set_index    = a[OFFSET_W+SET_OUT_W-1:OFFSET_W];
    r.req.tag          = a[ADDR_W-1:OFFSET_W+SET_OUT_W];
    s = r.req.set_index;
    accesses_total = accesses_total + COUNT_W'(1);
    if (valid_way0[s] && tag_way0[s] == r.req.tag) begin
      r.way = WAY0;
    end else if (valid_way1[s] && tag_way1[s] == r.req.tag) begin
      r.way = WAY1;
    end else begin
      misses_total = misses_total + COUNT_W'(1);
      r.miss = 1'b1;
      if (mru_way[s] == WAY1) begin
        if (valid_way0[s]) begin
          r.replacement = 1'b1;
          r.evicted_tag = tag_way0[s];
        end
        r.way = WAY0;
        tag_way0[s] = r.req.tag;
        valid_way0[s] = 1'b1;
      end else begin
        if (valid_way1[s]) begin
          r.replacement = 1'b1;
          r.evicted_tag = tag_way1[s];
        end
        r.way = WAY1;
        tag_way1[s] = r.req.tag;
        valid_way1[s] = 1'b1;
      end
    end
    mru_way[s] = r.way;
    r.miss_count = misses_total;
    r.access_count = accesses_total;
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        tag_way0[i] = '0;
        tag_way1[i] = '0;
        valid_way0[i] = 1'b0;
        valid_way1[i] = 1'b0;
        mru_way[i] = WAY1;
      end
      misses_total = '0;
      accesses_total = '0;
      expected_lookups.delete();
    end else begin
      if (push && !full) begin
        expected_lookups.push_back(predict_lookup(address));
      end
      if (pop && !empty) begin
        if (expected_lookups.size() == 0) begin
          mismatch_count++;
          $display("%0t: result beat with no lookup outstanding, expected none, actual tag %0h",
                   $time, tag);
        end else begin
          want = expected_lookups.pop_front();
          compare_field("byte_offset", 64'(want.req.byte_offset), 64'(byte_offset));
          compare_field("block_number", 64'(want.req.block_number), 64'(block_number));
          compare_field("set_index", 64'(want.req.set_index), 64'(set_index));
          compare_field("way", 64'(want.way), 64'(way));
          compare_field("tag", 64'(want.req.tag), 64'(tag));
          compare_field("miss", 64'(want.miss), 64'(miss));
          compare_field("replacement", 64'(want.replacement), 64'(replacement));
          compare_field("evicted_tag", 64'(want.evicted_tag), 64'(evicted_tag));
          compare_field("miss_count", 64'(want.miss_count), 64'(miss_count));
          compare_field("access_count", 64'(want.access_count), 64'(access_count));
        end
      end
    end
    queued = expected_lookups.size();
  end

endmodule

[tb/two_way_lru_cache_tag_lookup_test.sv]
`timescale 1ns / 100ps
// Top of the testbench for the two-way LRU cache tag lookup: clock, reset, address stimulus, result pops.
// Depends on tlk_pkg, the block two_way_lru_cache_tag_lookup and tag_lookup_monitor.
module two_way_lru_cache_tag_lookup_test;
  import tlk_pkg::*;

  localparam int RANDOM_LOOKUPS = 1750;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [ADDR_W-1:0]    address;
  logic                 empty;
  logic                 pop;
  logic [OFFSET_W-1:0]  byte_offset;
  logic [BLOCK_W-1:0]   block_number;
  logic [SET_OUT_W-1:0] set_index;
  logic                 way;
  logic [TAG_W-1:0]     tag;
  logic                 miss;
  logic                 replacement;
  logic [TAG_W-1:0]     evicted_tag;
  logic [COUNT_W-1:0]   miss_count;
  logic [COUNT_W-1:0]   access_count;
  int                   failures;
  int                   pending;

  logic [ADDR_W-1:0]    recent_addrs [16];
  int                   history_slot = 0;
  logic [SET_OUT_W-1:0] hot_sets [4];
  logic [TAG_W-1:0]     hot_tags [3];
  bit                   sender_calm = 1'b0;
  bit                   receiver_calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  two_way_lru_cache_tag_lookup dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .address(address),
    .empty(empty), .pop(pop), .byte_offset(byte_offset), .block_number(block_number),
    .set_index(set_index), .way(way), .tag(tag), .miss(miss), .replacement(replacement),
    .evicted_tag(evicted_tag), .miss_count(miss_count), .access_count(access_count)
  );

  tag_lookup_monitor monitor (
    .clk(clk), .rst(rst), .push(push), .full(full), .address(address),
    .empty(empty), .pop(pop), .byte_offset(byte_offset), .block_number(block_number),
    .set_index(set_index), .way(way), .tag(tag), .miss(miss), .replacement(replacement),
    .evicted_tag(evicted_tag), .miss_count(miss_count), .access_count(access_count),
    .failures(failures), .pending(pending)
  );

  task automatic send_address(input logic [ADDR_W-1:0] a);
    int gap;
    gap = sender_calm ? 0 : int'($urandom_range(0, 7));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    address <= a;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_lookups();
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic refresh_hot_spots();
    for (int i = 0; i < 4; i++) hot_sets[i] = SET_OUT_W'($urandom);
    for (int i = 0; i < 3; i++) hot_tags[i] = TAG_W'($urandom);
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      a = recent_addrs[$urandom_range(0, 15)];
      a[OFFSET_W-1:0] = OFFSET_W'($urandom);
    end else if (kind < 7) begin
      a = $urandom;
      a[OFFSET_W+SET_OUT_W-1:OFFSET_W] = hot_sets[$urandom_range(0, 3)];
      a[ADDR_W-1:OFFSET_W+SET_OUT_W] = hot_tags[$urandom_range(0, 2)];
    end else begin
      a = $urandom;
    end
    recent_addrs[history_slot] = a;
    history_slot = (history_slot + 1) % 16;
    return a;
  endfunction

  initial begin
    int stall;
    int served;
    pop = 1'b0;
    served = 0;
    @(negedge clk);
    forever begin
      if (served % 64 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      stall = receiver_calm ? 0 : int'($urandom_range(0, 7));
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty || rst) @(posedge clk);
      served++;
      @(negedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    address = '0;
    for (int i = 0; i < 16; i++) recent_addrs[i] = $urandom;
    refresh_hot_spots();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_address(32'h0000_0000);
    send_address(32'h0000_001F);
    send_address(32'hFFFF_FFFF);
    send_address(32'hFFFF_FFE0);
    send_address(32'h0000_0800);
    send_address(32'h0000_0000);
    send_address(32'h0000_1000);
    send_address(32'h0000_0800);
    send_address(32'h0000_1010);
    send_address(32'h7FFF_F7E0);
    send_address(32'h8000_0000);
    send_address(32'h0000_0020);
    send_address(32'h0000_0020);
    send_address(32'hAAAA_AAAA);
    send_address(32'h5555_5555);
    send_address(32'h5555_5540);
    send_address(32'hFFFF_F800);
    send_address(32'hFFFF_FFFF);
    drain_lookups();

    for (int n = 0; n < RANDOM_LOOKUPS; n++) begin
      if (n % 64 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      if (n % 256 == 255) refresh_hot_spots();
      if (n == RANDOM_LOOKUPS / 2) drain_lookups();
      send_address(pick_address());
    end
    push <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (failures == 0) begin
      $display("two_way_lru_cache_tag_lookup_test OK");
    end else begin
      $display("two_way_lru_cache_tag_lookup_test NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("two_way_lru_cache_tag_lookup_test NOT OK");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/tlk_pkg.sv
design/tlk_front.sv
design/tlk_back.sv
design/two_way_lru_cache_tag_lookup.sv
tb/tag_lookup_monitor.sv
tb/two_way_lru_cache_tag_lookup_test.sv
